[rtl/cace_pkg.sv]
// ----------------------------------------------------------------------------
// cace_pkg
// Shared types, codes and constants of the CAN address claim engine.
// ----------------------------------------------------------------------------
package cace_pkg;

  // Widths of fields
  localparam int unsigned NameW   = 64;
  localparam int unsigned AddrW   = 8;
  localparam int unsigned IdW     = 29;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  // Map size default and decoupling queue depth
  localparam int unsigned MapEntriesDef = 8;
  localparam int unsigned QueueDepth    = 2;

  // Protocol constants
  localparam logic [AddrW-1:0] NullAddr      = 8'd254;
  localparam logic [AddrW-1:0] GlobalAddr    = 8'd255;
  localparam logic [7:0]       ClaimFormat   = 8'hEE;
  localparam logic [7:0]       RequestFormat = 8'hEA;
  localparam logic [23:0]      ClaimPgn      = 24'd60928;
  localparam logic [IdW-1:0]   ClaimIdBase   = 29'h18EEFF00;
  localparam logic [TicksW-1:0] TicksMax     = 16'hFFFF;
  localparam logic [TicksW-1:0] WaitTicksRst = 16'd250;

  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_START  = 2'd2,
    CMD_LOOKUP = 2'd3
  } cace_cmd_e;

  typedef enum logic [1:0] {
    MODE_INIT        = 2'd0,
    MODE_CLAIMING    = 2'd1,
    MODE_LOST        = 2'd2,
    MODE_OPERATIONAL = 2'd3
  } cace_mode_e;

  typedef enum logic [1:0] {
    CFG_NODE_NAME  = 2'd0,
    CFG_PREF_ADDR  = 2'd1,
    CFG_WAIT_TICKS = 2'd2
  } cace_cfg_e;

  // Operation classes handed from the front to the back
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_CLAIM   = 3'd1,
    OP_REQUEST = 3'd2,
    OP_TICK    = 3'd3,
    OP_START   = 3'd4,
    OP_LOOKUP  = 3'd5
  } cace_op_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_READ   = 3'd2,
    S_CHECK  = 3'd3,
    S_ADD    = 3'd4,
    S_EMIT   = 3'd5
  } cace_state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             extended_frame;
    logic [IdW-1:0]   frame_id;
    logic [NameW-1:0] frame_payload;
    logic [AddrW-1:0] query_address;
  } cace_in_t;

  typedef struct packed {
    logic             send_valid;
    logic [IdW-1:0]   send_id;
    logic [NameW-1:0] send_payload;
    logic             frame_handled;
    logic [1:0]       claim_state;
    logic [AddrW-1:0] current_address;
    logic             lookup_found;
    logic [NameW-1:0] lookup_name;
  } cace_out_t;

  // addr: source of a claim, destination of a request, query of a lookup
  typedef struct packed {
    cace_op_e         kind;
    logic [AddrW-1:0] addr;
    logic             req_hit;
    logic [NameW-1:0] payload;
  } cace_op_t;

  typedef struct packed {
    logic [NameW-1:0]  node_name;
    logic [AddrW-1:0]  preferred_address;
    logic [TicksW-1:0] claim_wait_ticks;
  } cace_cfg_t;

endpackage

[rtl/cace_stream_if.sv]
// ----------------------------------------------------------------------------
// cace_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface cace_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/can_address_claim_engine.sv]
// ----------------------------------------------------------------------------
// can_address_claim_engine
// Address claim engine for a node on an extended-identifier CAN bus.
// ----------------------------------------------------------------------------
// Each input word (received frame, millisecond tick, start, or name lookup)
// yields exactly one result word with the claim frame to send, if any, and
// the claim state and own address after the word. The front end classifies
// words and parks them in a two-entry queue, so it keeps taking words while
// the back end works; the back end runs one word at a time. A tick, start,
// request or ignored frame goes only through the decode and emit steps. A
// claim from another node and a lookup walk the address map, stored in a
// RAM with one write port, one read port and a registered read, with a
// read and a check step per entry. Results leave through an output
// register, so the next word is processed while a finished result waits.
// Per-entry valid bits, cleared at reset, mark the map empty at once; no
// clearing pass is needed.
// Configuration words are taken on any cycle with cfg_we_i high and index
// values beyond the register list are dropped; write only while idle.
// ----------------------------------------------------------------------------
module can_address_claim_engine #(
  parameter int unsigned MapEntries = cace_pkg::MapEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cace_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cace_pkg::CfgW-1:0]     cfg_wdata_i,
  cace_stream_if.sink                   in_if,
  cace_stream_if.source                 out_if
);

  cace_pkg::cace_cfg_t cfg_q;

  logic               f_valid, f_ready;
  cace_pkg::cace_op_t f_op;
  logic               b_valid, b_ready;
  cace_pkg::cace_op_t b_op;

  // Configuration registers: hold until rewritten, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_name         <= '0;
      cfg_q.preferred_address <= '0;
      cfg_q.claim_wait_ticks  <= cace_pkg::WaitTicksRst;
    end else if (cfg_we_i) begin
      case (cace_pkg::cace_cfg_e'(cfg_index_i))
        cace_pkg::CFG_NODE_NAME:  cfg_q.node_name         <= cfg_wdata_i;
        cace_pkg::CFG_PREF_ADDR:  cfg_q.preferred_address <= cfg_wdata_i[cace_pkg::AddrW-1:0];
        cace_pkg::CFG_WAIT_TICKS: cfg_q.claim_wait_ticks  <= cfg_wdata_i[cace_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each accepted word
  cace_front u_front (
    .in_if      (in_if),
    .op_valid_o (f_valid),
    .op_o       (f_op),
    .op_ready_i (f_ready)
  );

  // Decoupling queue: lets the front keep accepting during a map walk
  cace_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_op),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_data_o   (b_op),
    .pop_ready_i  (b_ready)
  );

  // Back end: claim state machine, map walk and result register
  cace_back #(
    .MapEntries (MapEntries)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (b_valid),
    .op_i       (b_op),
    .op_ready_o (b_ready),
    .out_if     (out_if)
  );

endmodule

[rtl/cace_ram.sv]
// ----------------------------------------------------------------------------
// cace_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cace_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cace_front.sv]
// ----------------------------------------------------------------------------
// cace_front
// Accept input words and classify them into operations for the back end.
// ----------------------------------------------------------------------------
module cace_front (
  cace_stream_if.sink          in_if,
  output logic                 op_valid_o,
  output cace_pkg::cace_op_t   op_o,
  input  logic                 op_ready_i
);

  logic [7:0]  format;
  logic [7:0]  dest;
  logic [7:0]  src;
  logic [23:0] req_pgn;

  assign format  = in_if.data.frame_id[23:16];
  assign dest    = in_if.data.frame_id[15:8];
  assign src     = in_if.data.frame_id[7:0];
  // requested PGN is little endian in bytes 0..2
  assign req_pgn = {in_if.data.frame_payload[47:40], in_if.data.frame_payload[55:48],
                    in_if.data.frame_payload[63:56]};

  always_comb begin
    op_o.kind    = cace_pkg::OP_NOP;
    op_o.addr    = in_if.data.query_address;
    op_o.req_hit = (req_pgn == cace_pkg::ClaimPgn) && (src == cace_pkg::NullAddr);
    op_o.payload = in_if.data.frame_payload;
    case (cace_pkg::cace_cmd_e'(in_if.data.cmd))
      cace_pkg::CMD_FRAME: begin
        if (in_if.data.extended_frame) begin
          if (format == cace_pkg::ClaimFormat) begin
            op_o.kind = cace_pkg::OP_CLAIM;
            op_o.addr = src;
          end else if (format == cace_pkg::RequestFormat) begin
            op_o.kind = cace_pkg::OP_REQUEST;
            op_o.addr = dest;
          end
        end
      end
      cace_pkg::CMD_TICK:   op_o.kind = cace_pkg::OP_TICK;
      cace_pkg::CMD_START:  op_o.kind = cace_pkg::OP_START;
      cace_pkg::CMD_LOOKUP: op_o.kind = cace_pkg::OP_LOOKUP;
      default:              op_o.kind = cace_pkg::OP_NOP;
    endcase
  end

  assign op_valid_o  = in_if.valid;
  assign in_if.ready = op_ready_i;

endmodule

[rtl/cace_queue.sv]
// ----------------------------------------------------------------------------
// cace_queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
module cace_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  cace_pkg::cace_op_t push_data_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output cace_pkg::cace_op_t pop_data_o,
  input  logic               pop_ready_i
);

  localparam int unsigned Depth = cace_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cace_pkg::cace_op_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/cace_back.sv]
// ----------------------------------------------------------------------------
// cace_back
// Execute operations: claim state, wait counter, map walk, result register.
// ----------------------------------------------------------------------------
module cace_back #(
  parameter int unsigned MapEntries = cace_pkg::MapEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cace_pkg::cace_cfg_t cfg_i,
  input  logic                op_valid_i,
  input  cace_pkg::cace_op_t  op_i,
  output logic                op_ready_o,
  cace_stream_if.source       out_if
);

  localparam int unsigned IdxW   = (MapEntries > 1) ? $clog2(MapEntries) : 1;
  localparam int unsigned NameW  = cace_pkg::NameW;
  localparam int unsigned AddrW  = cace_pkg::AddrW;
  localparam int unsigned EntryW = AddrW + NameW;

  cace_pkg::cace_state_e state_q, state_d;
  cace_pkg::cace_mode_e  mode_q, mode_d;
  logic [AddrW-1:0]            own_q, own_d;
  logic [cace_pkg::TicksW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [MapEntries-1:0]       valid_q, valid_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [IdxW-1:0]             free_idx_q, free_idx_d;
  logic                        free_found_q, free_found_d;
  cace_pkg::cace_op_t          op_q, op_d;
  logic                        send_q, send_d;
  logic                        handled_q, handled_d;
  logic                        found_q, found_d;
  logic [NameW-1:0]            lname_q, lname_d;
  logic                        out_valid_q, out_valid_d;
  cace_pkg::cace_out_t         out_q, out_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic             frame_ok, is_map_upd, is_lookup_walk, walk;
  logic             ent_valid, hit_remove, hit_replace, hit_lookup, is_last, out_free;
  logic [AddrW-1:0] e_addr;
  logic [NameW-1:0] e_name;

  cace_ram #(
    .Width (EntryW),
    .Depth (MapEntries)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign frame_ok       = (mode_q == cace_pkg::MODE_CLAIMING) ||
                          (mode_q == cace_pkg::MODE_OPERATIONAL);
  assign is_map_upd     = (op_q.kind == cace_pkg::OP_CLAIM) && frame_ok && (op_q.addr != own_q);
  assign is_lookup_walk = (op_q.kind == cace_pkg::OP_LOOKUP) &&
                          (op_q.addr != cace_pkg::NullAddr);
  assign walk           = is_map_upd || is_lookup_walk;

  assign ent_valid   = valid_q[idx_q];
  assign e_addr      = ram_rdata[EntryW-1:NameW];
  assign e_name      = ram_rdata[NameW-1:0];
  assign hit_remove  = ent_valid && (op_q.addr == cace_pkg::NullAddr) &&
                       (e_name == op_q.payload);
  assign hit_replace = ent_valid && (e_addr == op_q.addr) && (e_name > op_q.payload);
  assign hit_lookup  = ent_valid && (e_addr == op_q.addr);
  assign is_last     = (idx_q == IdxW'(MapEntries - 1));
  assign out_free    = !out_valid_q || out_if.ready;
  assign cnt_inc     = (cnt_q == cace_pkg::TicksMax) ? cnt_q : cnt_q + 1'b1;

  assign op_ready_o   = (state_q == cace_pkg::S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cace_pkg::S_IDLE: begin
        if (op_valid_i) state_d = cace_pkg::S_DECODE;
      end
      cace_pkg::S_DECODE: state_d = walk ? cace_pkg::S_READ : cace_pkg::S_EMIT;
      cace_pkg::S_READ:   state_d = cace_pkg::S_CHECK;
      cace_pkg::S_CHECK: begin
        if (op_q.kind == cace_pkg::OP_LOOKUP) begin
          state_d = (hit_lookup || is_last) ? cace_pkg::S_EMIT : cace_pkg::S_READ;
        end else if (hit_remove || hit_replace) begin
          state_d = cace_pkg::S_EMIT;
        end else begin
          state_d = is_last ? cace_pkg::S_ADD : cace_pkg::S_READ;
        end
      end
      cace_pkg::S_ADD: state_d = cace_pkg::S_EMIT;
      cace_pkg::S_EMIT: begin
        if (out_free) state_d = cace_pkg::S_IDLE;
      end
      default: state_d = cace_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d       = mode_q;
    own_d        = own_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    op_d         = op_q;
    send_d       = send_q;
    handled_d    = handled_q;
    found_d      = found_q;
    lname_d      = lname_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = {op_q.addr, op_q.payload};

    case (state_q)
      cace_pkg::S_IDLE: begin
        if (op_valid_i) begin
          op_d      = op_i;
          send_d    = 1'b0;
          handled_d = 1'b0;
          found_d   = 1'b0;
          lname_d   = '0;
        end
      end
      cace_pkg::S_DECODE: begin
        idx_d        = '0;
        free_found_d = 1'b0;
        case (op_q.kind)
          cace_pkg::OP_TICK: begin
            if (mode_q == cace_pkg::MODE_CLAIMING) begin
              if (cnt_inc >= cfg_i.claim_wait_ticks) begin
                mode_d = cace_pkg::MODE_OPERATIONAL;
                cnt_d  = '0;
              end else begin
                cnt_d = cnt_inc;
              end
            end
          end
          cace_pkg::OP_START: begin
            if (mode_q == cace_pkg::MODE_INIT) own_d = cfg_i.preferred_address;
            send_d = 1'b1;
            cnt_d  = '0;
            mode_d = cace_pkg::MODE_CLAIMING;
          end
          cace_pkg::OP_CLAIM: begin
            if (frame_ok) begin
              handled_d = 1'b1;
              if (op_q.addr == own_q) begin
                send_d = 1'b1;
                cnt_d  = '0;
                if (!(cfg_i.node_name < op_q.payload)) begin
                  own_d  = cace_pkg::NullAddr;
                  mode_d = cace_pkg::MODE_LOST;
                end
              end
            end
          end
          cace_pkg::OP_REQUEST: begin
            if (frame_ok) begin
              handled_d = 1'b1;
              if (op_q.req_hit && (op_q.addr == own_q || op_q.addr == cace_pkg::GlobalAddr))
              begin
                send_d = 1'b1;
                cnt_d  = '0;
              end
            end
          end
          default: ;
        endcase
      end
      cace_pkg::S_CHECK: begin
        if (!is_last) idx_d = idx_q + 1'b1;
        if (op_q.kind == cace_pkg::OP_LOOKUP) begin
          if (hit_lookup) begin
            found_d = 1'b1;
            lname_d = e_name;
          end
        end else if (hit_remove) begin
          valid_d[idx_q] = 1'b0;
        end else if (hit_replace) begin
          ram_we = 1'b1;
        end else if (!ent_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
      end
      cace_pkg::S_ADD: begin
        // no entry matched: take the first free slot
        ram_waddr = free_idx_q;
        if (free_found_q && op_q.addr != cace_pkg::NullAddr) begin
          ram_we              = 1'b1;
          valid_d[free_idx_q] = 1'b1;
        end
      end
      cace_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.send_valid      = send_q;
          out_d.send_id         = send_q ? (cace_pkg::ClaimIdBase | {21'd0, own_q}) : '0;
          out_d.send_payload    = send_q ? cfg_i.node_name : '0;
          out_d.frame_handled   = handled_q;
          out_d.claim_state     = mode_q;
          out_d.current_address = own_q;
          out_d.lookup_found    = found_q;
          out_d.lookup_name     = lname_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cace_pkg::S_IDLE;
      mode_q       <= cace_pkg::MODE_INIT;
      own_q        <= cace_pkg::NullAddr;
      cnt_q        <= '0;
      valid_q      <= '0;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      own_q        <= own_d;
      cnt_q        <= cnt_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    free_idx_q <= free_idx_d;
    send_q     <= send_d;
    handled_q  <= handled_d;
    found_q    <= found_d;
    lname_q    <= lname_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  a_lost_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == cace_pkg::MODE_LOST |-> own_q == cace_pkg::NullAddr)
    else $error("lost mode with a non-null own address");

  a_map_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == cace_pkg::S_CHECK || state_q == cace_pkg::S_ADD))
    else $error("map written outside a map walk");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == cace_pkg::S_EMIT)
    else $error("result loaded outside the emit step");

  a_claim_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.send_valid |-> out_q.send_id[28:8] == cace_pkg::ClaimIdBase[28:8])
    else $error("claim word with a bad identifier");
`endif

endmodule
